@@ hdl/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed bump allocator package
// Shared widths, codes, defaults and the pipeline record between stages.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int HANDLE_W     = 32;
    localparam int SIZE_W       = 20;
    localparam int BUCKET_IDX_W = 12;
    localparam int OFFSET_OUT_W = 20;
    localparam int STATUS_W     = 3;

    localparam int DEF_OFFSET_BITS  = 20;
    localparam int DEF_MAX_BUCKETS  = 4096;
    localparam int DEF_HEADER_BYTES = 4;

    localparam logic [HANDLE_W-1:0] ALIGN_MASK = ~(HANDLE_W'(3));
    localparam logic [HANDLE_W-1:0] ALIGN_ADD  = HANDLE_W'(3);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_CHECK = 1'b1
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_SIZE_TOO_BIG = 3'd1,
        ST_EXHAUSTED    = 3'd2,
        ST_OUT_OF_RANGE = 3'd3,
        ST_UNEXP_NULL   = 3'd4
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]     handle;
        logic [BUCKET_IDX_W-1:0] bidx;
        logic [OFFSET_OUT_W-1:0] boff;
        logic                    is_null;
        status_t                 status;
        logic                    chk;
        logic                    use_cur;
        logic [HANDLE_W-1:0]     fill;
    } s1_t;

    function automatic longint unsigned bucket_limit(input int ob, input int mb);
        longint unsigned addr_buckets;
        addr_buckets = 64'd1 << (HANDLE_W - ob);
        return (longint'(mb) < addr_buckets) ? longint'(mb) : addr_buckets;
    endfunction

endpackage

@@ hdl/bucketed_bump_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed bump allocator unit
// Never-freeing arena allocator handing out bucket/offset handles and
// validating handles against the filled extent of their bucket.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the result channel stalls; a request is
// held in a request register beside the registered read of the fill table,
// then moves to the result register. Allocations update the live bucket and
// fill registers in the accept cycle, so a following check always sees them.
// The fill table needs no clearing after reset: only closed-bucket entries matter.
// ----------------------------------------------------------------------------
module bucketed_bump_allocator_unit import bba_pkg::*; #(
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [SIZE_W-1:0]       s_alloc_size,
    input  logic [HANDLE_W-1:0]     s_handle_in,
    input  logic                    s_null_ok,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [HANDLE_W-1:0]     m_handle_out,
    output logic [BUCKET_IDX_W-1:0] m_bucket_index,
    output logic [OFFSET_OUT_W-1:0] m_bucket_offset,
    output logic                    m_is_null,
    output logic [STATUS_W-1:0]     m_status
);

    localparam longint unsigned LIMIT = bucket_limit(OFFSET_BITS, MAX_BUCKETS);
    localparam int CB_W  = $clog2(LIMIT);
    localparam int DEPTH = int'(LIMIT);

    logic                   accept;
    s1_t                    s1_data;
    logic                   tbl_wr_en, tbl_rd_en;
    logic [CB_W-1:0]        tbl_wr_addr, tbl_rd_addr;
    logic [OFFSET_BITS-1:0] tbl_wr_data, tbl_rd_data;

    assign accept = s_valid && s_ready;

    bba_front #(
        .OFFSET_BITS  (OFFSET_BITS),
        .MAX_BUCKETS  (MAX_BUCKETS),
        .HEADER_BYTES (HEADER_BYTES),
        .CB_W         (CB_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req_type    (s_req_type),
        .alloc_size  (s_alloc_size),
        .handle_in   (s_handle_in),
        .null_ok     (s_null_ok),
        .s1_data     (s1_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr)
    );

    bba_fill_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (CB_W),
        .DATA_W (OFFSET_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    bba_resolve #(
        .OFFSET_BITS  (OFFSET_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_resolve (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .s1_in           (s1_data),
        .tbl_rd_data     (tbl_rd_data),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_handle_out    (m_handle_out),
        .m_bucket_index  (m_bucket_index),
        .m_bucket_offset (m_bucket_offset),
        .m_is_null       (m_is_null),
        .m_status        (m_status)
    );

endmodule

@@ hdl/bba_fill_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closed bucket fill table
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module bba_fill_table #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 20
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bba_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator front stage
// Holds the current bucket and fill, serves allocations, closes buckets into
// the fill table and prepares check requests for the resolve stage.
// ----------------------------------------------------------------------------
module bba_front import bba_pkg::*; #(
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int CB_W         = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   req_type,
    input  logic [SIZE_W-1:0]      alloc_size,
    input  logic [HANDLE_W-1:0]    handle_in,
    input  logic                   null_ok,
    output s1_t                    s1_data,
    output logic                   tbl_wr_en,
    output logic [CB_W-1:0]        tbl_wr_addr,
    output logic [OFFSET_BITS-1:0] tbl_wr_data,
    output logic                   tbl_rd_en,
    output logic [CB_W-1:0]        tbl_rd_addr
);

    localparam longint unsigned LIMIT = bucket_limit(OFFSET_BITS, MAX_BUCKETS);
    localparam logic [HANDLE_W-1:0] DATA_BYTES =
        HANDLE_W'((64'd1 << OFFSET_BITS) - 64'(HEADER_BYTES));
    localparam logic [HANDLE_W-1:0] OFF_MASK =
        HANDLE_W'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [HANDLE_W-1:0] HDR = HANDLE_W'(HEADER_BYTES);
    localparam logic [HANDLE_W:0]   LIMIT_W = (HANDLE_W+1)'(LIMIT);

    logic [CB_W-1:0]        cur_reg, cur_next;
    logic [OFFSET_BITS-1:0] fill_reg, fill_next;

    logic [HANDLE_W-1:0] cur32, cur_inc32, fill32, size32, aligned32, base32;
    logic [HANDLE_W-1:0] bucket32, off32, bucket_sel32, off_alloc32;
    logic                too_big, need_new, last_bucket, alloc_go, is_alloc;

    always_comb begin
        is_alloc    = (req_type == REQ_ALLOC);
        cur32       = HANDLE_W'(cur_reg);
        cur_inc32   = cur32 + HANDLE_W'(1);
        fill32      = HANDLE_W'(fill_reg);
        size32      = HANDLE_W'(alloc_size);
        aligned32   = (fill32 + ALIGN_ADD) & ALIGN_MASK;
        too_big     = (size32 >= DATA_BYTES);
        need_new    = (aligned32 > DATA_BYTES) || (size32 > (DATA_BYTES - aligned32));
        last_bucket = ((HANDLE_W+1)'(cur32) + (HANDLE_W+1)'(1)) >= LIMIT_W;
        base32      = need_new ? '0 : aligned32;
        alloc_go    = accept && is_alloc && !too_big && !(need_new && last_bucket);
        bucket_sel32 = need_new ? cur_inc32 : cur32;
        off_alloc32  = HDR + base32;

        bucket32 = handle_in >> OFFSET_BITS;
        off32    = handle_in & OFF_MASK;

        cur_next  = cur_reg;
        fill_next = fill_reg;
        if (alloc_go) begin
            if (need_new) begin
                cur_next = cur_reg + CB_W'(1);
            end
            fill_next = OFFSET_BITS'(base32 + size32);
        end

        tbl_wr_en   = alloc_go && need_new;
        tbl_wr_addr = cur_reg;
        tbl_wr_data = fill_reg;
        tbl_rd_en   = accept && !is_alloc;
        tbl_rd_addr = bucket32[CB_W-1:0];

        s1_data         = '0;
        s1_data.status  = ST_OK;
        s1_data.fill    = fill32;
        if (is_alloc) begin
            if (too_big) begin
                s1_data.status = ST_SIZE_TOO_BIG;
            end else if (need_new && last_bucket) begin
                s1_data.status = ST_EXHAUSTED;
            end else begin
                s1_data.handle = (bucket_sel32 << OFFSET_BITS) + off_alloc32;
                s1_data.bidx   = bucket_sel32[BUCKET_IDX_W-1:0];
                s1_data.boff   = off_alloc32[OFFSET_OUT_W-1:0];
            end
        end else if (handle_in == '0) begin
            s1_data.is_null = null_ok;
            s1_data.status  = null_ok ? ST_OK : ST_UNEXP_NULL;
        end else begin
            s1_data.handle = handle_in;
            s1_data.bidx   = bucket32[BUCKET_IDX_W-1:0];
            s1_data.boff   = off32[OFFSET_OUT_W-1:0];
            if ((bucket32 > cur32) || (off32 < HDR)) begin
                s1_data.status = ST_OUT_OF_RANGE;
            end else begin
                s1_data.chk     = 1'b1;
                s1_data.use_cur = (bucket32 == cur32);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            fill_reg <= '0;
        end else begin
            cur_reg  <= cur_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hdl/bba_resolve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Check resolve and result register
// Compares a checked offset with the fill from the table or the live bucket
// and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module bba_resolve import bba_pkg::*; #(
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  s1_t                     s1_in,
    input  logic [OFFSET_BITS-1:0]  tbl_rd_data,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [HANDLE_W-1:0]     m_handle_out,
    output logic [BUCKET_IDX_W-1:0] m_bucket_index,
    output logic [OFFSET_OUT_W-1:0] m_bucket_offset,
    output logic                    m_is_null,
    output logic [STATUS_W-1:0]     m_status
);

    localparam logic [HANDLE_W-1:0] OFF_MASK =
        HANDLE_W'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [HANDLE_W-1:0] HDR = HANDLE_W'(HEADER_BYTES);

    logic                    s1_valid_reg, s1_valid_next;
    s1_t                     s1_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]     out_handle_reg;
    logic [BUCKET_IDX_W-1:0] out_bidx_reg;
    logic [OFFSET_OUT_W-1:0] out_boff_reg;
    logic                    out_null_reg;
    status_t                 out_status_reg, status_res;
    logic [HANDLE_W-1:0]     fill32, off32;
    logic                    adv, bad;

    always_comb begin
        adv    = !out_valid_reg || m_ready;
        fill32 = s1_reg.use_cur ? s1_reg.fill : HANDLE_W'(tbl_rd_data);
        off32  = s1_reg.handle & OFF_MASK;
        bad    = s1_reg.chk && ((off32 - HDR) > fill32);
        status_res = bad ? ST_OUT_OF_RANGE : s1_reg.status;

        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (adv) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = s1_valid_reg;
        end
    end

    assign s_ready = !s1_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_in;
        end
        if (adv && s1_valid_reg) begin
            out_handle_reg <= s1_reg.handle;
            out_bidx_reg   <= s1_reg.bidx;
            out_boff_reg   <= s1_reg.boff;
            out_null_reg   <= s1_reg.is_null;
            out_status_reg <= status_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_handle_out    = out_handle_reg;
    assign m_bucket_index  = out_bidx_reg;
    assign m_bucket_offset = out_boff_reg;
    assign m_is_null       = out_null_reg;
    assign m_status        = out_status_reg;

endmodule

@@ hdl/bba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed bump allocator port checker
// Watches the result channel for stable stalls and consistent result codes.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [HANDLE_W-1:0]     m_handle_out,
    input logic                    m_is_null,
    input logic [STATUS_W-1:0]     m_status
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_handle_out)
                                && $stable(m_status) && $stable(m_is_null))
        else $error("result changed while stalled");

    a_null_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_null |-> m_handle_out == '0 && m_status == ST_OK)
        else $error("null result with handle or error");

    a_status_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_UNEXP_NULL)
        else $error("result with unknown status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_SIZE_TOO_BIG || m_status == ST_EXHAUSTED
                    || m_status == ST_UNEXP_NULL)
        |-> m_handle_out == '0 && !m_is_null)
        else $error("error result carries a handle");

endmodule

bind bucketed_bump_allocator_unit bba_checker u_bba_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_handle_out (m_handle_out),
    .m_is_null    (m_is_null),
    .m_status     (m_status)
);

@@ verif/tb_bucketed_bump_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed bump allocator unit testbench
// Drives allocate and check requests through a short table of corner cases,
// then random traffic under several sender and receiver idling mixes and one
// long receiver hold-off.
// Each result is compared field by field, in order, with a prediction or a table entry.
// ----------------------------------------------------------------------------
module tb_bucketed_bump_allocator_unit;
    import bba_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int QUIET_LIMIT    = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_PER_PHASE = 330;
    localparam int TAIL_ITEMS     = 60;

    localparam int OFF_BITS = DEF_OFFSET_BITS;
    localparam int HDR      = DEF_HEADER_BYTES;
    localparam logic [31:0] DATA_BYTES  = (32'd1 << OFF_BITS) - HDR;
    localparam logic [31:0] OFF_MASK    = (32'd1 << OFF_BITS) - 1;
    localparam longint ADDR_BUCKETS     = 64'd1 << (HANDLE_W - OFF_BITS);
    localparam longint NUM_BUCKETS      =
        (DEF_MAX_BUCKETS < ADDR_BUCKETS) ? DEF_MAX_BUCKETS : ADDR_BUCKETS;
    localparam logic [31:0] LAST_BUCKET = 32'(NUM_BUCKETS - 1);

    localparam int IDLE_PLAN  [4] = '{0, 76, 0, 18};
    localparam int STALL_PLAN [4] = '{0, 0, 76, 18};

    typedef struct packed {
        req_type_t           kind;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
        logic                null_ok;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]     handle;
        logic [BUCKET_IDX_W-1:0] bidx;
        logic [OFFSET_OUT_W-1:0] boff;
        logic                    is_null;
        status_t                 status;
    } res_t;

    typedef struct packed {
        req_t req;
        logic typed;
        res_t res;
    } dir_row_t;

    localparam res_t NO_RES = '{32'h0, 12'h0, 20'h0, 1'b0, ST_OK};

    localparam int N_DIR = 23;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{'{REQ_CHECK, 20'd0, 32'h0000_0000, 1'b1}, 1'b1,
          '{32'h0, 12'd0, 20'd0, 1'b1, ST_OK}},
        '{'{REQ_CHECK, 20'd0, 32'h0000_0000, 1'b0}, 1'b1,
          '{32'h0, 12'd0, 20'd0, 1'b0, ST_UNEXP_NULL}},
        '{'{REQ_ALLOC, 20'd1048575, 32'h0, 1'b0}, 1'b1,
          '{32'h0, 12'd0, 20'd0, 1'b0, ST_SIZE_TOO_BIG}},
        '{'{REQ_ALLOC, 20'd1048572, 32'h0, 1'b0}, 1'b1,
          '{32'h0, 12'd0, 20'd0, 1'b0, ST_SIZE_TOO_BIG}},
        '{'{REQ_ALLOC, 20'd0, 32'h0, 1'b0}, 1'b1,
          '{32'h4, 12'd0, 20'd4, 1'b0, ST_OK}},
        '{'{REQ_ALLOC, 20'd1, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_ALLOC, 20'd5, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0000_0004, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0000_000D, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0000_000E, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0000_0003, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0010_0004, 1'b0}, 1'b1,
          '{32'h0010_0004, 12'd1, 20'd4, 1'b0, ST_OUT_OF_RANGE}},
        '{'{REQ_CHECK, 20'd0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{32'hFFFF_FFFF, 12'hFFF, 20'hFFFFF, 1'b0, ST_OUT_OF_RANGE}},
        '{'{REQ_ALLOC, 20'd1048571, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_ALLOC, 20'd0, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h001F_FFFF, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0010_0003, 1'b1}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h000F_FFFF, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0000_000D, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_ALLOC, 20'd1, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_CHECK, 20'd0, 32'h0020_0004, 1'b1}, 1'b0, NO_RES},
        '{'{REQ_ALLOC, 20'hAAAAA, 32'h0, 1'b0}, 1'b0, NO_RES},
        '{'{REQ_ALLOC, 20'h55555, 32'h0, 1'b0}, 1'b0, NO_RES}
    };

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic                    s_req_type      = 1'b0;
    logic [SIZE_W-1:0]       s_alloc_size    = '0;
    logic [HANDLE_W-1:0]     s_handle_in     = '0;
    logic                    s_null_ok       = 1'b0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [HANDLE_W-1:0]     m_handle_out;
    logic [BUCKET_IDX_W-1:0] m_bucket_index;
    logic [OFFSET_OUT_W-1:0] m_bucket_offset;
    logic                    m_is_null;
    logic [STATUS_W-1:0]     m_status;

    // allocator state as predicted
    logic [31:0] cur_bucket = '0;
    logic [31:0] cur_fill   = '0;
    logic [31:0] closed_fill [DEF_MAX_BUCKETS];

    res_t        pending_results [$];
    logic [31:0] granted_handles [$];
    res_t        oldest_result;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          hold_req     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;

    bucketed_bump_allocator_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_alloc_size    (s_alloc_size),
        .s_handle_in     (s_handle_in),
        .s_null_ok       (s_null_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_handle_out    (m_handle_out),
        .m_bucket_index  (m_bucket_index),
        .m_bucket_offset (m_bucket_offset),
        .m_is_null       (m_is_null),
        .m_status        (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic res_t resolve_request(input req_t r);
        res_t        res;
        logic [31:0] aligned;
        logic [31:0] off;
        logic [31:0] fill;
        logic [31:0] b;
        logic        bad;
        res = NO_RES;
        if (r.kind == REQ_ALLOC) begin
            aligned = (cur_fill + 32'd3) & ~32'd3;
            if (32'(r.size) >= DATA_BYTES) begin
                res.status = ST_SIZE_TOO_BIG;
            end else if ((aligned > DATA_BYTES || 32'(r.size) > DATA_BYTES - aligned)
                         && cur_bucket >= LAST_BUCKET) begin
                res.status = ST_EXHAUSTED;
            end else begin
                if (aligned > DATA_BYTES || 32'(r.size) > DATA_BYTES - aligned) begin
                    closed_fill[cur_bucket] = cur_fill;
                    cur_bucket = cur_bucket + 1;
                    cur_fill   = '0;
                    aligned    = '0;
                end
                off        = HDR + aligned;
                res.handle = (cur_bucket << OFF_BITS) + off;
                res.bidx   = cur_bucket[BUCKET_IDX_W-1:0];
                res.boff   = off[OFFSET_OUT_W-1:0];
                cur_fill   = aligned + 32'(r.size);
            end
        end else if (r.handle == '0) begin
            if (r.null_ok) begin
                res.is_null = 1'b1;
            end else begin
                res.status = ST_UNEXP_NULL;
            end
        end else begin
            b   = r.handle >> OFF_BITS;
            off = r.handle & OFF_MASK;
            bad = (b > cur_bucket) || (off < HDR);
            if (!bad) begin
                fill = (b == cur_bucket) ? cur_fill : closed_fill[b];
                bad  = (off - HDR) > fill;
            end
            res.handle = r.handle;
            res.bidx   = b[BUCKET_IDX_W-1:0];
            res.boff   = off[OFFSET_OUT_W-1:0];
            if (bad) res.status = ST_OUT_OF_RANGE;
        end
        return res;
    endfunction

    function automatic req_t rand_request();
        req_t        r;
        int unsigned pick;
        logic [31:0] b;
        logic [31:0] off;
        r.kind       = REQ_ALLOC;
        r.size       = SIZE_W'($urandom);
        r.handle     = $urandom;
        r.null_ok    = 1'($urandom_range(1, 0));
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                r.size = SIZE_W'($urandom_range(64, 0));
            end else if (pick < 85) begin
                r.size = SIZE_W'($urandom_range(8192, 0));
            end else if (pick < 95) begin
                r.size = SIZE_W'($urandom_range(DATA_BYTES - 1, DATA_BYTES / 2));
            end else if (pick < 97) begin
                r.size = SIZE_W'($urandom_range(OFF_MASK, DATA_BYTES));
            end
        end else begin
            r.kind = REQ_CHECK;
            pick = $urandom_range(99, 0);
            if (pick < 25 && granted_handles.size() != 0) begin
                r.handle = granted_handles[$urandom_range(granted_handles.size() - 1, 0)];
            end else if (pick < 60) begin
                // land near the filled extent of a live or closed bucket
                b   = $urandom_range(cur_bucket, 0);
                off = HDR + ((b == cur_bucket) ? cur_fill : closed_fill[b])
                      + $urandom_range(12, 0) - 6;
                r.handle = {b[BUCKET_IDX_W-1:0], off[OFFSET_OUT_W-1:0]};
            end else if (pick < 70) begin
                r.handle = '0;
            end else if (pick < 80 && cur_bucket < LAST_BUCKET) begin
                b = $urandom_range(LAST_BUCKET, cur_bucket + 1);
                r.handle = {b[BUCKET_IDX_W-1:0], OFFSET_OUT_W'($urandom)};
            end else if (pick < 88) begin
                b = $urandom_range(cur_bucket, 0);
                r.handle = {b[BUCKET_IDX_W-1:0], OFFSET_OUT_W'($urandom_range(HDR - 1, 0))};
            end
        end
        return r;
    endfunction

    task automatic send_request(input req_t r, input logic typed, input res_t typed_res);
        res_t res;
        while ($urandom_range(99, 0) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= r.kind;
        s_alloc_size <= r.size;
        s_handle_in  <= r.handle;
        s_null_ok    <= r.null_ok;
        do @(posedge aclk); while (!s_ready);
        res = resolve_request(r);
        if (r.kind == REQ_ALLOC && res.status == ST_OK) begin
            granted_handles.push_back(res.handle);
            if (granted_handles.size() > 256) void'(granted_handles.pop_front());
        end
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: handle_out expected none actual %h", $time, m_handle_out);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("handle_out", oldest_result.handle, m_handle_out);
                check_field("bucket_index", oldest_result.bidx, m_bucket_index);
                check_field("bucket_offset", oldest_result.boff, m_bucket_offset);
                check_field("is_null", oldest_result.is_null, m_is_null);
                check_field("status", oldest_result.status, m_status);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end

        for (int p = 0; p < 4; p++) begin
            idle_pct  = IDLE_PLAN[p];
            stall_pct <= STALL_PLAN[p];
            // hold the receiver off while requests keep coming
            if (p == 0) hold_req <= hold_req + 1;
            repeat (RAND_PER_PHASE) send_request(rand_request(), 1'b0, NO_RES);
        end

        idle_pct  = 18;
        stall_pct <= 18;
        repeat (TAIL_ITEMS) send_request(rand_request(), 1'b0, NO_RES);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bba_pkg.sv
hdl/bba_fill_table.sv
hdl/bba_front.sv
hdl/bba_resolve.sv
hdl/bucketed_bump_allocator_unit.sv
hdl/bba_checker.sv
verif/tb_bucketed_bump_allocator_unit.sv
